[sv/linear_blend_skinning_macros.svh]
// Shared assertion macros for the skinning block checkers.
`ifndef LINEAR_BLEND_SKINNING_MACROS_SVH
`define LINEAR_BLEND_SKINNING_MACROS_SVH

// Check that the consequent holds in the same cycle as the trigger.
`define LBS_ASSERT_NOW(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("skinning check failed");

// Check that the consequent holds in the cycle after the trigger.
`define LBS_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("skinning check failed");

`endif

[sv/lbs_pkg.sv]
`default_nettype none
package lbs_pkg;
	// command codes
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_LOAD  = 2'd0;
	localparam cmd_t CMD_SKIN  = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	// matrix layout: 3x3 rotation then a translation row
	localparam int ELEMS      = 12;
	localparam int TRANS_BASE = 9;

	// weight scale and rounding bias
	localparam int WSCALE = 65535;
	localparam int WBIAS  = 32767;

	typedef logic signed [32:0] term_t;
endpackage
`default_nettype wire

[sv/lbs_ram.sv]
`default_nettype none
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[sv/linear_blend_skinning.sv]
`default_nettype none
// Channel   Ports                                          Direction  Handshake
// command   start, busy, command .. norm_z                 in         start & !busy
// result    done, out_vertex, sum_pos_*, sum_norm_*         out        done, one cycle
//
// A load writes the matrix RAM and leaves busy low.
// A skin pair holds busy: the FETCH state reads the bone matrix, then the multiplies,
// weight roundings and the reciprocal fix-ups of each division share one multiplier;
// the ADD state then writes the sums, and done follows in the next cycle.
// A clear, and reset, sweep the touched RAM one vertex a cycle, busy until every vertex is cleared.
// The result is shown for one cycle on done; the receiver cannot stall it.
module linear_blend_skinning #(
	parameter int MAX_VERTS = 4096,
	parameter int MAX_BONES = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire lbs_pkg::cmd_t       command,
	input  wire logic [5:0]          bone_index,
	input  wire logic [3:0]          element_index,
	input  wire logic signed [31:0]  element_value,
	input  wire logic [11:0]         vertex_index,
	input  wire logic [15:0]         weight,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic signed [31:0]  pos_z,
	input  wire logic signed [7:0]   norm_x,
	input  wire logic signed [7:0]   norm_y,
	input  wire logic signed [7:0]   norm_z,
	output logic                     done,
	output logic [11:0]              out_vertex,
	output logic signed [31:0]       sum_pos_x,
	output logic signed [31:0]       sum_pos_y,
	output logic signed [31:0]       sum_pos_z,
	output logic signed [31:0]       sum_norm_x,
	output logic signed [31:0]       sum_norm_y,
	output logic signed [31:0]       sum_norm_z
);
	import lbs_pkg::*;

	localparam int MDEPTH = MAX_BONES * ELEMS;
	localparam int MAW    = MDEPTH > 1 ? $clog2(MDEPTH) : 1;
	localparam int VAW    = MAX_VERTS > 1 ? $clog2(MAX_VERTS) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_ACC   = 4'd4;
	localparam logic [3:0] S_WMUL  = 4'd5;
	localparam logic [3:0] S_WACC  = 4'd6;
	localparam logic [3:0] S_WFIX  = 4'd7;
	localparam logic [3:0] S_ADD   = 4'd8;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -49'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] acc_add(input logic signed [31:0] base,
			input term_t add);
		logic signed [48:0] s;
		s = 49'(base) + 49'(add);
		return sat32(s);
	endfunction

	// control state
	logic [3:0]     state_q;
	logic [VAW:0]   sweep_q;
	logic [3:0]     fetch_q;
	logic [1:0]     col_q;
	logic [1:0]     row_q;
	logic           kind_q;
	logic           wsel_q;
	logic           done_q;

	// payload state
	logic [5:0]             bone_q;
	logic [11:0]            vtx_q;
	logic [15:0]            w_q;
	logic signed [31:0]     p_q [3];
	logic signed [7:0]      n_q [3];
	logic signed [31:0]     m_q [ELEMS];
	logic signed [65:0]     prod_q;
	logic signed [48:0]     tp_q;
	logic signed [41:0]     tn_q;
	logic                   neg_q;
	logic [33:0]            q_q;
	logic [18:0]            r_q;
	term_t                  sp_q [3];
	term_t                  sn_q [3];
	logic [11:0]            ov_q;
	logic signed [31:0]     os_q [6];

	// RAM ports
	logic              mat_we;
	logic [MAW-1:0]    mat_waddr;
	logic [MAW-1:0]    mat_raddr;
	logic [31:0]       mat_rdata;
	logic              tch_we;
	logic [VAW-1:0]    tch_waddr;
	logic [0:0]        tch_wdata;
	logic [0:0]        tch_rdata;
	logic              acc_we;
	logic [VAW-1:0]    vaddr;
	logic [191:0]      acc_wdata;
	logic [191:0]      acc_rdata;

	logic              accept;
	logic              skin_ok;
	logic [3:0]        midx;
	logic [3:0]        tidx;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod;
	logic signed [31:0] t_sat;
	logic [47:0]       wx;
	logic [49:0]       q0;
	logic [49:0]       rr;
	logic [32:0]       qmag;
	term_t             tfin;
	logic signed [31:0] nsum [6];
	logic signed [31:0] base [6];

	assign accept  = start && !busy;
	assign skin_ok = (int'(bone_index) < MAX_BONES) && (int'(vertex_index) < MAX_VERTS);
	assign midx    = 4'({row_q, 1'b0}) + 4'(row_q) + 4'(col_q);
	assign tidx    = 4'(TRANS_BASE) + 4'(col_q);
	assign vaddr   = VAW'(vtx_q);

	// select operands of the shared multiplier
	always_comb begin
		t_sat = wsel_q ? sat32(49'($signed(tn_q[41:6]))) : sat32(tp_q);
		if (state_q == S_WMUL) begin
			mul_a = t_sat[31] ? -33'(t_sat) : 33'(t_sat);
			mul_b = $signed({17'b0, w_q});
		end else begin
			mul_a = kind_q ? 33'(n_q[row_q]) : 33'(p_q[row_q]);
			mul_b = 33'(m_q[midx]);
		end
		prod = mul_a * mul_b;
	end

	// divide by the weight scale: reciprocal estimate and remainder
	always_comb begin
		wx   = prod_q[47:0] + 48'(WBIAS);
		q0   = 50'(wx >> 16) + 50'(wx >> 32);
		rr   = 50'(wx) - ((q0 << 16) - q0);
		qmag = q_q[32:0];
		tfin = neg_q ? -$signed(qmag) : $signed(qmag);
	end

	// new accumulator sums
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			base[i] = tch_rdata[0] ? $signed(acc_rdata[32*i +: 32]) : 32'sd0;
		end
		for (int i = 0; i < 3; i++) begin
			nsum[i]     = acc_add(base[i], sp_q[i]);
			nsum[i + 3] = acc_add(base[i + 3], sn_q[i]);
		end
		for (int i = 0; i < 6; i++) begin
			acc_wdata[32*i +: 32] = nsum[i];
		end
	end

	assign mat_we    = accept && (command == CMD_LOAD) && (int'(bone_index) < MAX_BONES)
		&& (int'(element_index) < ELEMS);
	assign mat_waddr = MAW'(32'(bone_index) * ELEMS + 32'(element_index));
	assign mat_raddr = MAW'(32'(bone_q) * ELEMS + 32'(fetch_q));
	assign tch_we    = (state_q == S_CLR) || (state_q == S_ADD);
	assign tch_waddr = (state_q == S_CLR) ? sweep_q[VAW-1:0] : vaddr;
	assign tch_wdata = (state_q == S_ADD) ? 1'b1 : 1'b0;
	assign acc_we    = (state_q == S_ADD);

	lbs_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(element_value),
		.raddr(mat_raddr), .rdata(mat_rdata)
	);

	lbs_ram #(.WIDTH(1), .DEPTH(MAX_VERTS)) u_tch (
		.clk(clk), .we(tch_we), .waddr(tch_waddr), .wdata(tch_wdata),
		.raddr(vaddr), .rdata(tch_rdata)
	);

	lbs_ram #(.WIDTH(192), .DEPTH(MAX_VERTS)) u_acc (
		.clk(clk), .we(acc_we), .waddr(vaddr), .wdata(acc_wdata),
		.raddr(vaddr), .rdata(acc_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sweep_q <= '0;
			fetch_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			kind_q  <= 1'b0;
			wsel_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_ADD);
			unique case (state_q)
				S_IDLE: begin
					if (accept && command == CMD_CLEAR) begin
						sweep_q <= '0;
						state_q <= S_CLR;
					end else if (accept && command == CMD_SKIN && skin_ok) begin
						fetch_q <= '0;
						state_q <= S_FETCH;
					end
				end
				S_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (int'(sweep_q) == MAX_VERTS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_FETCH: begin
					fetch_q <= fetch_q + 1'b1;
					if (int'(fetch_q) == ELEMS) begin
						col_q   <= '0;
						row_q   <= '0;
						kind_q  <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (row_q != 2'd2) begin
						row_q   <= row_q + 1'b1;
						state_q <= S_MUL;
					end else if (!kind_q) begin
						row_q   <= '0;
						kind_q  <= 1'b1;
						state_q <= S_MUL;
					end else begin
						wsel_q  <= 1'b0;
						state_q <= S_WMUL;
					end
				end
				S_WMUL: begin
					state_q <= S_WACC;
				end
				S_WACC: begin
					state_q <= S_WFIX;
				end
				S_WFIX: begin
					if (r_q < 19'(WSCALE)) begin
						if (!wsel_q) begin
							wsel_q  <= 1'b1;
							state_q <= S_WMUL;
						end else if (col_q != 2'd2) begin
							col_q   <= col_q + 1'b1;
							row_q   <= '0;
							kind_q  <= 1'b0;
							state_q <= S_MUL;
						end else begin
							state_q <= S_ADD;
						end
					end
				end
				S_ADD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			bone_q <= bone_index;
			vtx_q  <= vertex_index;
			w_q    <= weight;
			p_q[0] <= pos_x;
			p_q[1] <= pos_y;
			p_q[2] <= pos_z;
			n_q[0] <= norm_x;
			n_q[1] <= norm_y;
			n_q[2] <= norm_z;
		end
		if (state_q == S_FETCH && fetch_q != 4'd0) begin
			m_q[fetch_q - 4'd1] <= mat_rdata;
		end
		if (state_q == S_FETCH && int'(fetch_q) == ELEMS) begin
			tp_q <= 49'($signed(m_q[TRANS_BASE]));
			tn_q <= '0;
		end
		if (state_q == S_MUL || state_q == S_WMUL) begin
			prod_q <= prod;
		end
		if (state_q == S_WMUL) begin
			neg_q <= t_sat[31];
		end
		if (state_q == S_ACC) begin
			if (!kind_q) begin
				tp_q <= tp_q + $signed(prod_q[64:16]);
			end else begin
				tn_q <= tn_q + $signed(prod_q[41:0]);
			end
		end
		if (state_q == S_WACC) begin
			q_q <= q0[33:0];
			r_q <= rr[18:0];
		end
		if (state_q == S_WFIX) begin
			if (r_q >= 19'(WSCALE)) begin
				r_q <= r_q - 19'(WSCALE);
				q_q <= q_q + 1'b1;
			end else begin
				if (!wsel_q) begin
					sp_q[col_q] <= tfin;
				end else begin
					sn_q[col_q] <= tfin;
				end
				if (wsel_q && col_q != 2'd2) begin
					tp_q <= 49'($signed(m_q[tidx + 4'd1]));
					tn_q <= '0;
				end
			end
		end
		if (state_q == S_ADD) begin
			ov_q <= vtx_q;
			for (int i = 0; i < 6; i++) begin
				os_q[i] <= nsum[i];
			end
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign out_vertex = ov_q;
	assign sum_pos_x  = os_q[0];
	assign sum_pos_y  = os_q[1];
	assign sum_pos_z  = os_q[2];
	assign sum_norm_x = os_q[3];
	assign sum_norm_y = os_q[4];
	assign sum_norm_z = os_q[5];
endmodule
`default_nettype wire

[sv/lbs_checker.sv]
`default_nettype none
`include "linear_blend_skinning_macros.svh"
module lbs_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire lbs_pkg::cmd_t command,
	input wire logic          done
);
	import lbs_pkg::*;

	// a result beat closes a busy stretch
	`LBS_ASSERT_NOW(a_done_after_busy, done, $past(busy))
	// one result beat per item
	`LBS_ASSERT_NEXT(a_done_single, done, !done)
	// a clear always starts a sweep
	`LBS_ASSERT_NEXT(a_clear_busy, start && !busy && command == CMD_CLEAR, busy && !done)
	// a load completes in its own cycle
	`LBS_ASSERT_NEXT(a_load_quick, start && !busy && command == CMD_LOAD, !busy && !done)
endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.command(command), .done(done)
);
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import lbs_pkg::*;

	typedef struct {
		logic [11:0]        vtx;
		logic signed [31:0] px, py, pz, nx, ny, nz;
	} sums_t;

	typedef struct {
		cmd_t               cmd;
		logic [5:0]         bone;
		logic [3:0]         elem;
		logic signed [31:0] val;
		logic [11:0]        vtx;
		logic [15:0]        w;
		logic signed [31:0] p [3];
		logic signed [7:0]  n [3];
		bit                 has_sums;
		sums_t              sums;
	} beat_t;

	localparam cmd_t CMD_NONE = 2'd3;
	localparam int N_RANDOM = 2000;
	localparam int CALM_TAIL = 300;

	logic clk, arst_n, start, busy, done;
	cmd_t command;
	logic [5:0] bone_index;
	logic [3:0] element_index;
	logic signed [31:0] element_value;
	logic [11:0] vertex_index;
	logic [15:0] weight;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [7:0] norm_x, norm_y, norm_z;
	logic [11:0] out_vertex;
	logic signed [31:0] sum_pos_x, sum_pos_y, sum_pos_z;
	logic signed [31:0] sum_norm_x, sum_norm_y, sum_norm_z;

	// shadow state of the block
	logic signed [31:0] bone_mat [64][12];
	bit                 elem_loaded [64][12];
	bit                 vtx_touched [4096];
	logic signed [31:0] acc [4096][6];

	sums_t expected_sums [$];
	int errors = 0;
	int n_loads = 0, n_skins = 0, n_clears = 0, n_results = 0;

	linear_blend_skinning DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round(t * w / 65535) to nearest, symmetric about zero
	function automatic longint weigh(input longint t, input longint w);
		longint mag, q;
		mag = (t < 0 ? -t : t) * w;
		q = (mag + WBIAS) / WSCALE;
		return t < 0 ? -q : q;
	endfunction

	// transform, weight and accumulate one pair; update the shadow state
	function automatic sums_t skin_vertex(input beat_t b);
		longint tp, tn, m, add [6];
		longint base;
		sums_t s;
		for (int c = 0; c < 3; c++) begin
			tp = bone_mat[b.bone][TRANS_BASE + c];
			tn = 0;
			for (int r = 0; r < 3; r++) begin
				m = bone_mat[b.bone][3 * r + c];
				tp += (longint'(b.p[r]) * m) >>> 16;
				tn += longint'(b.n[r]) * m;
			end
			add[c] = weigh(sat32(tp), b.w);
			add[3 + c] = weigh(sat32(tn >>> 6), b.w);
		end
		for (int i = 0; i < 6; i++) begin
			base = vtx_touched[b.vtx] ? longint'(acc[b.vtx][i]) : 0;
			acc[b.vtx][i] = sat32(base + add[i]);
		end
		vtx_touched[b.vtx] = 1;
		s.vtx = b.vtx;
		s.px = acc[b.vtx][0]; s.py = acc[b.vtx][1]; s.pz = acc[b.vtx][2];
		s.nx = acc[b.vtx][3]; s.ny = acc[b.vtx][4]; s.nz = acc[b.vtx][5];
		return s;
	endfunction

	function automatic beat_t mk(input cmd_t cmd, input int bone, input int elem,
			input logic [31:0] val, input int vtx, input int w,
			input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
			input logic [7:0] nx, input logic [7:0] ny, input logic [7:0] nz);
		beat_t b;
		b.cmd = cmd; b.bone = bone; b.elem = elem; b.val = val;
		b.vtx = vtx; b.w = w;
		b.p[0] = px; b.p[1] = py; b.p[2] = pz;
		b.n[0] = nx; b.n[1] = ny; b.n[2] = nz;
		b.has_sums = 0;
		b.sums = '{default: '0};
		return b;
	endfunction

	// mostly moderate Q16.16 values, sometimes extremes or raw bits
	function automatic logic [31:0] rand_q(input int span);
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	// drive one beat, hold until accepted, then advance the shadow state
	task automatic send(input beat_t b, input bit may_idle);
		sums_t s;
		if (may_idle && $urandom_range(0, 5) == 0) begin
			start = 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		command = b.cmd; bone_index = b.bone; element_index = b.elem;
		element_value = b.val; vertex_index = b.vtx; weight = b.w;
		pos_x = b.p[0]; pos_y = b.p[1]; pos_z = b.p[2];
		norm_x = b.n[0]; norm_y = b.n[1]; norm_z = b.n[2];
		start = 1;
		do @(posedge clk); while (busy);
		case (b.cmd)
			CMD_LOAD: begin
				n_loads++;
				if (b.elem < ELEMS) begin
					bone_mat[b.bone][b.elem] = b.val;
					elem_loaded[b.bone][b.elem] = 1;
				end
			end
			CMD_CLEAR: begin
				n_clears++;
				vtx_touched = '{default: 0};
			end
			CMD_SKIN: begin
				n_skins++;
				s = skin_vertex(b);
				expected_sums.push_back(b.has_sums ? b.sums : s);
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		sums_t e;
		if (arst_n && done) begin
			n_results++;
			if (expected_sums.size() == 0) begin
				report("unexpected result", out_vertex, 0);
			end else begin
				e = expected_sums.pop_front();
				if (out_vertex !== e.vtx) report("out_vertex", out_vertex, e.vtx);
				if (sum_pos_x !== e.px) report("sum_pos_x", sum_pos_x, e.px);
				if (sum_pos_y !== e.py) report("sum_pos_y", sum_pos_y, e.py);
				if (sum_pos_z !== e.pz) report("sum_pos_z", sum_pos_z, e.pz);
				if (sum_norm_x !== e.nx) report("sum_norm_x", sum_norm_x, e.nx);
				if (sum_norm_y !== e.ny) report("sum_norm_y", sum_norm_y, e.ny);
				if (sum_norm_z !== e.nz) report("sum_norm_z", sum_norm_z, e.nz);
			end
		end
	end

	initial begin
		beat_t table_rows [$];
		beat_t b;
		int ready_bones [$];
		int bone, pick, wait_cycles;
		bit full;

		arst_n = 0; start = 0; command = CMD_LOAD;
		bone_index = 0; element_index = 0; element_value = 0; vertex_index = 0;
		weight = 0; pos_x = 0; pos_y = 0; pos_z = 0; norm_x = 0; norm_y = 0; norm_z = 0;
		elem_loaded = '{default: '{default: 0}};
		vtx_touched = '{default: 0};
		repeat (11) @(negedge clk);
		arst_n = 1;

		// directed: identity bone 0, extremes, saturation, ignored beats, clear
		for (int k = 0; k < ELEMS; k++)
			table_rows.push_back(mk(CMD_LOAD, 0, k, (k % 4 == 0) ? 65536 : 0,
				0, 0, 0, 0, 0, 0, 0, 0));
		b = mk(CMD_SKIN, 0, 0, 0, 0, 65535, 32'h7fffffff, 32'h80000000, 0, 127, -128, 0);
		b.has_sums = 1;
		b.sums = '{0, 32'h7fffffff, 32'h80000000, 0, 127 * 1024, -128 * 1024, 0};
		table_rows.push_back(b);
		b.sums = '{0, 32'h7fffffff, 32'h80000000, 0, 254 * 1024, -256 * 1024, 0};
		table_rows.push_back(b);
		b = mk(CMD_SKIN, 0, 0, 0, 4095, 0, 32'h12345678, -5, 7, 127, 1, -1);
		b.has_sums = 1;
		b.sums = '{4095, 0, 0, 0, 0, 0, 0};
		table_rows.push_back(b);
		table_rows.push_back(mk(CMD_LOAD, 0, 12, 32'hdeadbeef, 0, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(CMD_LOAD, 0, 15, 32'hffffffff, 0, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(CMD_NONE, 63, 15, 32'hffffffff, 4095, 65535,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 8'hff, 8'hff, 8'hff));
		table_rows.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		b = mk(CMD_SKIN, 0, 0, 0, 0, 65535, 1, 2, 3, 1, 1, 1);
		b.has_sums = 1;
		b.sums = '{0, 1, 2, 3, 1024, 1024, 1024};
		table_rows.push_back(b);
		table_rows.push_back(mk(CMD_LOAD, 63, 11, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0));
		foreach (table_rows[i]) send(table_rows[i], 1);

		// fully load a few bones so skinning has matrices to use
		for (int bn = 1; bn < 6; bn++)
			for (int k = 0; k < ELEMS; k++)
				send(mk(CMD_LOAD, bn, k, rand_q(1 << 17), 0, 0, 0, 0, 0, 0, 0, 0), 1);

		// random mix, mostly skin pairs on a small set of vertices
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				b = mk(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 15),
					rand_q(1 << 17), 0, 0, 0, 0, 0, 0, 0, 0);
			end else if (pick < 19) begin
				b = mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
			end else if (pick < 21) begin
				b = mk(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				// only bones whose every element has been written
				ready_bones.delete();
				for (int bn = 0; bn < 64; bn++) begin
					full = 1;
					for (int k = 0; k < ELEMS; k++) full &= elem_loaded[bn][k];
					if (full) ready_bones.push_back(bn);
				end
				bone = ready_bones[$urandom_range(0, ready_bones.size() - 1)];
				b = mk(CMD_SKIN, bone, $urandom, $urandom,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
						: $urandom_range(0, 15),
					($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1)) ? 65535 : 0)
						: $urandom_range(0, 65535),
					rand_q(1 << 22), rand_q(1 << 22), rand_q(1 << 22),
					$urandom, $urandom, $urandom);
			end
			send(b, i < N_RANDOM - CALM_TAIL);
		end
		start = 0;

		// drain outstanding results
		wait_cycles = 0;
		while (expected_sums.size() != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (expected_sums.size() != 0) begin
			$display("%0d expected results never arrived", expected_sums.size());
			errors++;
		end

		$display("Ran %0d loads, %0d skin pairs, %0d clears; %0d results checked",
			n_loads, n_skins, n_clears, n_results);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

[linear_blend_skinning.f]
+incdir+sv
sv/lbs_pkg.sv
sv/lbs_ram.sv
sv/linear_blend_skinning.sv
sv/lbs_checker.sv
test/testbench.sv
